@@ hdl/text_to_integer_parser_macros.svh @@
// Assertion macros used by the checker file ttip_checker.sv.
`ifndef TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_MACROS_SVH

// Checked only outside reset.
`define TTIP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TTIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ttip_pkg.sv @@
package ttip_pkg;

    localparam int CH_W       = 8;
    localparam int BASE_W     = 5;
    localparam int CONSUMED_W = 12;
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;

    localparam logic [BASE_W-1:0] BASE_DETECT = 5'd0;
    localparam logic [BASE_W-1:0] BASE_OCT    = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC    = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX    = 5'd16;
    localparam logic [BASE_W-1:0] BASE_BAD    = 5'd1;
    localparam logic [BASE_W-1:0] NO_DIGIT    = 5'd31;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_FIRST,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [BASE_W-1:0]   active_base;
        logic                negative;
    } ctrl_t;

    localparam ctrl_t CTRL_CLEAR = '{phase: PH_SPACE, active_base: BASE_DETECT, negative: 1'b0};

    function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [BASE_W-1:0] d;
        d = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39)
            d = BASE_W'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            d = BASE_W'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            d = BASE_W'(c - 8'h37);
        return d;
    endfunction

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

@@ hdl/ttip_cfg.sv @@
module ttip_cfg
    import ttip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic [BASE_W-1:0]     radix,
    output logic                  allow_minus
);

    typedef enum logic {
        REG_RADIX,
        REG_ALLOW_MINUS
    } reg_idx_t;

    logic [BASE_W-1:0] radix_reg;
    logic              allow_minus_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= BASE_DEC;
            allow_minus_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RADIX:       radix_reg       <= pwdata[BASE_W-1:0];
                REG_ALLOW_MINUS: allow_minus_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RADIX:       prdata = APB_DATA_W'(radix_reg);
            REG_ALLOW_MINUS: prdata = APB_DATA_W'(allow_minus_reg);
            default:         prdata = '0;
        endcase
    end

    assign radix       = radix_reg;
    assign allow_minus = allow_minus_reg;

endmodule

@@ hdl/ttip_step.sv @@
// Next-state and result logic for one text byte.
// The value is kept with its sign applied: v' = v * base +/- digit.
module ttip_step
    import ttip_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int COUNT_MAX  = 4095,
    parameter int CNT_W      = 12
)
(
    input  logic [CH_W-1:0]       ch,
    input  logic [BASE_W-1:0]     radix,
    input  logic                  allow_minus,
    input  ctrl_t                 ctrl,
    input  logic [VALUE_BITS-1:0] val,
    input  logic [CNT_W-1:0]      cnt,
    input  logic [CNT_W-1:0]      dend,
    output ctrl_t                 ctrl_next,
    output logic [VALUE_BITS-1:0] val_next,
    output logic [CNT_W-1:0]      cnt_next,
    output logic [CNT_W-1:0]      dend_next,
    output logic [VALUE_BITS-1:0] res_value,
    output logic [CONSUMED_W-1:0] res_consumed,
    output logic                  res_stopped
);

    function automatic logic [CNT_W-1:0] count_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_W'(COUNT_MAX)) ? c + 1'b1 : c;
    endfunction

    ctrl_t                 c_n;
    logic [VALUE_BITS-1:0] v_n;
    logic [CNT_W-1:0]      k_n;
    logic [CNT_W-1:0]      e_n;
    logic                  first;
    logic                  take;
    logic [BASE_W-1:0]     digit;
    logic [VALUE_BITS-1:0] prod;
    logic [VALUE_BITS-1:0] dterm;
    logic                  is_end;

    assign digit  = digit_of(ch);
    assign is_end = (ch == CH_NUL);

    always_comb
    begin
        c_n   = ctrl;
        v_n   = val;
        k_n   = cnt;
        e_n   = dend;
        first = 1'b0;
        take  = 1'b0;
        prod  = '0;
        dterm = '0;

        unique case (ctrl.phase) inside
            PH_SPACE:
            begin
                if (is_space(ch))
                    k_n = count_inc(cnt);
                else if (radix == BASE_BAD || radix > BASE_HEX)
                    c_n.phase = PH_STOP;
                else
                begin
                    c_n.active_base = radix;
                    if (ch == CH_MINUS && allow_minus)
                    begin
                        c_n.negative = 1'b1;
                        k_n          = count_inc(cnt);
                        c_n.phase    = PH_FIRST;
                    end
                    else if (ch == CH_PLUS)
                    begin
                        k_n       = count_inc(cnt);
                        c_n.phase = PH_FIRST;
                    end
                    else
                        first = 1'b1;
                end
            end
            PH_FIRST:
                first = 1'b1;
            PH_ZERO:
            begin
                if (ch == CH_LX || ch == CH_UX)
                begin
                    c_n.active_base = BASE_HEX;
                    k_n             = count_inc(cnt);
                    c_n.phase       = PH_HEXPFX;
                end
                else
                    take = 1'b1;
            end
            PH_HEXPFX, PH_DIGITS:
                take = 1'b1;
            default:
                c_n.phase = PH_STOP;
        endcase

        // leading zero may open an octal or hex prefix
        if (first)
        begin
            if (ch == CH_ZERO && (c_n.active_base == BASE_DETECT || c_n.active_base == BASE_HEX))
            begin
                k_n = count_inc(cnt);
                e_n = k_n;
                if (c_n.active_base == BASE_DETECT)
                    c_n.active_base = BASE_OCT;
                c_n.phase = PH_ZERO;
            end
            else
            begin
                if (c_n.active_base == BASE_DETECT)
                    c_n.active_base = BASE_DEC;
                take = 1'b1;
            end
        end

        if (take)
        begin
            if (digit < c_n.active_base)
            begin
                prod      = val * VALUE_BITS'(c_n.active_base);
                dterm     = c_n.negative ? VALUE_BITS'(0) - VALUE_BITS'(digit)
                                         : VALUE_BITS'(digit);
                v_n       = prod + dterm;
                k_n       = count_inc(cnt);
                e_n       = k_n;
                c_n.phase = PH_DIGITS;
            end
            else
                c_n.phase = PH_STOP;
        end

        // terminator: report the string as it stands, then clear
        if (is_end)
        begin
            res_value    = val;
            res_consumed = CONSUMED_W'(dend);
            res_stopped  = (ctrl.phase == PH_STOP);
            ctrl_next    = CTRL_CLEAR;
            val_next     = '0;
            cnt_next     = '0;
            dend_next    = '0;
        end
        else
        begin
            res_value    = v_n;
            res_consumed = CONSUMED_W'(e_n);
            res_stopped  = (c_n.phase == PH_STOP);
            ctrl_next    = c_n;
            val_next     = v_n;
            cnt_next     = k_n;
            dend_next    = e_n;
        end
    end

endmodule

@@ hdl/text_to_integer_parser.sv @@
// Streaming strtol/strtoul: one text byte per input beat, one result beat per byte.
// Leading white space is skipped, then an optional sign ('-' only when allow_minus
// is set), then the base is fixed from radix (0 detects 0x/0 prefixes). Digits
// below the base are accumulated with the sign applied, wrapping modulo
// 2^VALUE_BITS; the first other byte stops the parse and later bytes repeat the
// final result. A zero byte reports the final result with tlast set and clears
// the parser for the next string; radix and allow_minus are sampled once per
// string, when white space ends, and should be written only while the block is
// idle. Throughput is one byte per clock while the result side is not stalled:
// the value * base + digit recurrence in ttip_step closes through the parse
// state registers. A byte passes the input register, then the result register;
// both sides may stall at any time without losing beats. consumed is the
// end-pointer offset (bytes through the last digit), saturating at COUNT_MAX
// and shown in its low 12 bits; it is 0 when no digit was taken.
module text_to_integer_parser
    import ttip_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int COUNT_MAX  = 4095
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // input text bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CH_W-1:0]       s_tdata,   // [7:0] ch

    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((VALUE_BITS + CONSUMED_W + 7) / 8) * 8 - 1:0] m_tdata,
                                             // value, consumed, zero pad
    output logic                  m_tuser,   // [0] stopped
    output logic                  m_tlast,   // string_end (zero byte)

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DATA_W = ((VALUE_BITS + CONSUMED_W + 7) / 8) * 8;
    localparam int CNT_W  = $clog2(COUNT_MAX + 1);

    // configuration registers
    logic [BASE_W-1:0] radix;
    logic              allow_minus;

    // input register
    logic              s1_valid_reg;
    logic [CH_W-1:0]   s1_ch_reg;

    // parse state
    ctrl_t                 ctrl_reg,  ctrl_next;
    logic [VALUE_BITS-1:0] val_reg,   val_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic [CNT_W-1:0]      dend_reg,  dend_next;

    // result register
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [CONSUMED_W-1:0] out_consumed_reg;
    logic                  out_stopped_reg;
    logic                  out_last_reg;

    logic [VALUE_BITS-1:0] res_value;
    logic [CONSUMED_W-1:0] res_consumed;
    logic                  res_stopped;

    logic                  out_free;
    logic                  step_fire;
    logic                  in_beat;

    assign pready = 1'b1;

    ttip_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .radix       (radix),
        .allow_minus (allow_minus)
    );

    // result register frees when empty or being taken this cycle
    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || out_free;
    assign in_beat   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_beat)
            s1_valid_reg <= 1'b1;
        else if (step_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            s1_ch_reg <= s_tdata;
    end

    ttip_step #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_MAX  (COUNT_MAX),
        .CNT_W      (CNT_W)
    ) u_step (
        .ch           (s1_ch_reg),
        .radix        (radix),
        .allow_minus  (allow_minus),
        .ctrl         (ctrl_reg),
        .val          (val_reg),
        .cnt          (cnt_reg),
        .dend         (dend_reg),
        .ctrl_next    (ctrl_next),
        .val_next     (val_next),
        .cnt_next     (cnt_next),
        .dend_next    (dend_next),
        .res_value    (res_value),
        .res_consumed (res_consumed),
        .res_stopped  (res_stopped)
    );

    // parse state advances once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= CTRL_CLEAR;
            val_reg  <= '0;
            cnt_reg  <= '0;
            dend_reg <= '0;
        end
        else if (step_fire)
        begin
            ctrl_reg <= ctrl_next;
            val_reg  <= val_next;
            cnt_reg  <= cnt_next;
            dend_reg <= dend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_value_reg    <= res_value;
            out_consumed_reg <= res_consumed;
            out_stopped_reg  <= res_stopped;
            out_last_reg     <= (s1_ch_reg == CH_NUL);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'({out_consumed_reg, out_value_reg});
    assign m_tuser  = out_stopped_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hdl/ttip_checker.sv @@
`include "text_to_integer_parser_macros.svh"

module ttip_checker
    import ttip_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [((VALUE_BITS + CONSUMED_W + 7) / 8) * 8 - 1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    localparam int DATA_W = ((VALUE_BITS + CONSUMED_W + 7) / 8) * 8;

    logic              in_beat;
    logic              out_beat;
    logic [1:0]        pend_reg,  pend_next;
    logic              stop_seen_reg;
    logic [DATA_W-1:0] held_data_reg;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // bytes taken but not yet answered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_beat && !out_beat)
            pend_next = pend_reg + 2'd1;
        else if (out_beat && !in_beat)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            stop_seen_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_beat)
                stop_seen_reg <= m_tuser && !m_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_beat)
            held_data_reg <= m_tdata;
    end

    `TTIP_ASSERT_ALWAYS(a_no_beat_in_reset, clk, !rst_n |-> !m_tvalid, "result beat during reset")

    `TTIP_ASSERT(a_hold_on_stall, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

    `TTIP_ASSERT(a_pending_bound, clk, rst_n, pend_reg != 2'd3, "more than two bytes in flight")

    `TTIP_ASSERT(a_no_extra_result, clk, rst_n, m_tvalid |-> pend_reg != 2'd0, "result beat without a byte behind it")

    `TTIP_ASSERT(a_stop_repeats, clk, rst_n, m_tvalid && stop_seen_reg |-> m_tuser && m_tdata == held_data_reg, "result changed after the parse stopped")

endmodule

bind text_to_integer_parser ttip_checker #(.VALUE_BITS(VALUE_BITS)) u_ttip_checker (.*);
